/* src/divider_timer_with_modulo_reload_macros.svh */
// Assertion macros for the divider timer block.
`ifndef DIVIDER_TIMER_WITH_MODULO_RELOAD_MACROS_SVH
`define DIVIDER_TIMER_WITH_MODULO_RELOAD_MACROS_SVH

`ifndef ASSERT_OFF
`define DTM_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("dtm assertion failed");
`define DTM_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dtm assertion failed");
`else
`define DTM_ASSERT(lbl, cond)
`define DTM_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

/* src/dtm_pkg.sv */
// Types and constants shared by the divider timer block.
package dtm_pkg;

    typedef enum logic [1:0] {
        KIND_TICK  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_WRITE = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;

    localparam logic [7:0] UNMAPPED_DATA = 8'hFF;
    localparam logic [7:0] TAC_FORCE     = 8'b1111_1000;

    typedef enum logic [1:0] {
        SEL_BIT9 = 2'd0,
        SEL_BIT3 = 2'd1,
        SEL_BIT5 = 2'd2,
        SEL_BIT7 = 2'd3
    } clk_sel_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] address;
        logic [7:0]  write_data;
    } cmd_item_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
    } rsp_item_t;

    typedef struct packed {
        logic       pending;
        logic [2:0] countdown;
    } timer_status_t;

endpackage

/* src/dtm_cmd_if.sv */
// Handshake channel carrying tick and bus transactions into the block.
interface dtm_cmd_if;
    logic                 valid;
    logic                 ready;
    dtm_pkg::cmd_item_t   item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

/* src/dtm_rsp_if.sv */
// Handshake channel carrying results out of the block.
interface dtm_rsp_if;
    logic                 valid;
    logic                 ready;
    dtm_pkg::rsp_item_t   item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

/* src/dtm_core.sv */
// Timer state registers and single-pass tick/read/write logic.
module dtm_core #(
    parameter int unsigned RELOAD_DELAY = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step_en,
    input  dtm_pkg::cmd_item_t     cmd,
    output dtm_pkg::rsp_item_t     result,
    output dtm_pkg::timer_status_t status
);

    localparam logic [2:0] DELAY_INIT = 3'(RELOAD_DELAY);

    logic [15:0] div_reg, div_next;
    logic [7:0]  tima_reg, tima_next;
    logic [7:0]  tma_reg, tma_next;
    logic [7:0]  tac_reg, tac_next;
    logic        last_and_reg, last_and_next;
    logic        pend_reg, pend_next;
    logic [2:0]  cd_reg, cd_next;

    logic [15:0] div_inc;
    logic        sel_bit;
    logic        now_and;
    logic [7:0]  tima_inc;
    logic [2:0]  cd_dec;
    logic [7:0]  rd;
    logic        irq;

    always_comb
    begin
        div_inc = div_reg + 16'd1;
        case (dtm_pkg::clk_sel_t'(tac_reg[1:0]))
            dtm_pkg::SEL_BIT9: sel_bit = div_inc[9];
            dtm_pkg::SEL_BIT3: sel_bit = div_inc[3];
            dtm_pkg::SEL_BIT5: sel_bit = div_inc[5];
            dtm_pkg::SEL_BIT7: sel_bit = div_inc[7];
            default:           sel_bit = div_inc[7];
        endcase
        now_and  = sel_bit & tac_reg[2];
        tima_inc = tima_reg + 8'd1;
        cd_dec   = (cd_reg != 3'd0) ? cd_reg - 3'd1 : 3'd0;
    end

    always_comb
    begin
        div_next      = div_reg;
        tima_next     = tima_reg;
        tma_next      = tma_reg;
        tac_next      = tac_reg;
        last_and_next = last_and_reg;
        pend_next     = pend_reg;
        cd_next       = cd_reg;
        rd            = 8'd0;
        irq           = 1'b0;

        case (dtm_pkg::kind_t'(cmd.kind))
            dtm_pkg::KIND_TICK:
            begin
                div_next      = div_inc;
                last_and_next = now_and;
                if (pend_reg)
                begin
                    cd_next = cd_dec;
                    if (cd_dec == 3'd0)
                    begin
                        tima_next = tma_reg;
                        pend_next = 1'b0;
                        irq       = 1'b1;
                    end
                end
                else if (last_and_reg && !now_and)
                begin
                    tima_next = tima_inc;
                    if (tima_inc == 8'd0)
                    begin
                        if (DELAY_INIT == 3'd0)
                        begin
                            tima_next = tma_reg;
                            irq       = 1'b1;
                        end
                        else
                        begin
                            pend_next = 1'b1;
                            cd_next   = DELAY_INIT;
                        end
                    end
                end
            end
            dtm_pkg::KIND_READ:
            begin
                case (cmd.address)
                    dtm_pkg::ADDR_DIV:  rd = div_reg[15:8];
                    dtm_pkg::ADDR_TIMA: rd = tima_reg;
                    dtm_pkg::ADDR_TMA:  rd = tma_reg;
                    dtm_pkg::ADDR_TAC:  rd = tac_reg;
                    default:            rd = dtm_pkg::UNMAPPED_DATA;
                endcase
            end
            dtm_pkg::KIND_WRITE:
            begin
                case (cmd.address)
                    dtm_pkg::ADDR_DIV:  div_next  = 16'd0;
                    dtm_pkg::ADDR_TIMA: tima_next = cmd.write_data;
                    dtm_pkg::ADDR_TMA:  tma_next  = cmd.write_data;
                    dtm_pkg::ADDR_TAC:  tac_next  = cmd.write_data | dtm_pkg::TAC_FORCE;
                    default:            ;
                endcase
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_reg      <= 16'd0;
            tima_reg     <= 8'd0;
            tma_reg      <= 8'd0;
            tac_reg      <= 8'd0;
            last_and_reg <= 1'b0;
            pend_reg     <= 1'b0;
            cd_reg       <= 3'd0;
        end
        else if (step_en)
        begin
            div_reg      <= div_next;
            tima_reg     <= tima_next;
            tma_reg      <= tma_next;
            tac_reg      <= tac_next;
            last_and_reg <= last_and_next;
            pend_reg     <= pend_next;
            cd_reg       <= cd_next;
        end
    end

    assign result.read_data = rd;
    assign result.timer_irq = irq;
    assign status.pending   = pend_reg;
    assign status.countdown = cd_reg;

endmodule

/* src/divider_timer_with_modulo_reload.sv */
// Top level: input register, timer core and result register.
//
//  channel | dir | payload                          | handshake
//  cmd     | in  | kind, address, write_data        | valid/ready
//  rsp     | out | read_data, timer_irq             | valid/ready
//
// One transaction per cycle while rsp is not stalled; a cmd is registered in the input
// register, then its result in the result register, before rsp valid rises.
// The timer state registers update once per item, as it moves into the result register.
// Reset clears divider, counter, modulo, control and the reload state.
// A stalled rsp holds the result register; cmd keeps accepting while the
// input register is empty or moving into a free result register.
`include "divider_timer_with_modulo_reload_macros.svh"

module divider_timer_with_modulo_reload #(
    parameter int unsigned RELOAD_DELAY = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    dtm_cmd_if.sink   cmd,
    dtm_rsp_if.source rsp
);

    logic                   s1_valid_reg, s1_valid_next;
    dtm_pkg::cmd_item_t     s1_item_reg;
    logic                   out_valid_reg, out_valid_next;
    dtm_pkg::rsp_item_t     out_item_reg;
    dtm_pkg::rsp_item_t     core_result;
    dtm_pkg::timer_status_t core_status;
    logic                   out_free;
    logic                   advance;
    logic                   cmd_take;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign advance   = s1_valid_reg && out_free;
    assign cmd.ready = !s1_valid_reg || out_free;
    assign cmd_take  = cmd.valid && cmd.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (cmd_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take)
            s1_item_reg <= cmd.item;
        if (advance)
            out_item_reg <= core_result;
    end

    dtm_core #(
        .RELOAD_DELAY (RELOAD_DELAY)
    ) u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (advance),
        .cmd     (s1_item_reg),
        .result  (core_result),
        .status  (core_status)
    );

    assign rsp.valid = out_valid_reg;
    assign rsp.item  = out_item_reg;

    `DTM_ASSERT(a_idle_no_countdown, core_status.pending || (core_status.countdown == 3'd0))
    `DTM_ASSERT_IMPL(a_irq_no_data, rsp.valid && rsp.item.timer_irq, rsp.item.read_data == 8'd0)
    `DTM_ASSERT_IMPL(a_rsp_from_stage, $rose(rsp.valid), $past(advance))
    `DTM_ASSERT_IMPL(a_no_overrun, cmd_take && s1_valid_reg, advance)

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the divider timer block with modulo reload.
`timescale 1ns / 1ps

module tb_top;
    import dtm_pkg::*;

    localparam int unsigned RELOAD_TICKS = 4;
    localparam int unsigned RANDOM_ITEMS = 1900;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned MAX_REPORTS = 10;

    typedef struct packed {
        logic      preset;
        rsp_item_t value;
    } preset_t;

    typedef struct {
        cmd_item_t   cmd;
        int unsigned reps;
        bit          preset;
        logic [7:0]  read_data;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    dtm_cmd_if cmd_ch ();
    dtm_rsp_if rsp_ch ();

    divider_timer_with_modulo_reload #(
        .RELOAD_DELAY(RELOAD_TICKS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .cmd  (cmd_ch.sink),
        .rsp  (rsp_ch.source)
    );

    always #2 clk = ~clk;

    // timer state as the block should hold it
    logic [15:0] div_count = '0;
    logic [7:0]  tick_count = '0;
    logic [7:0]  reload_value = '0;
    logic [7:0]  ctrl_reg = '0;
    logic        prev_gate = 1'b0;
    logic        overflow_wait = 1'b0;
    logic [2:0]  reload_left = '0;

    rsp_item_t   due_results [$];
    preset_t     preset_q [$];
    plan_row_t   plan [$];

    bit          calm = 1'b0;
    int unsigned cycles = 0;
    int unsigned mismatches = 0;
    int unsigned n_ticks = 0;
    int unsigned n_reads = 0;
    int unsigned n_writes = 0;
    int unsigned n_other = 0;
    int unsigned irq_total = 0;
    int unsigned n_checked = 0;

    function automatic bit idle_roll();
        return !calm && ($urandom_range(0, 99) < 21);
    endfunction

    function automatic logic reload_now();
        tick_count = reload_value;
        overflow_wait = 1'b0;
        reload_left = '0;
        return 1'b1;
    endfunction

    function automatic rsp_item_t timer_step(input cmd_item_t c);
        rsp_item_t r;
        int unsigned sel;
        logic gate;
        logic was_waiting;
        r = '0;
        case (c.kind)
            KIND_TICK:
            begin
                case (ctrl_reg[1:0])
                    SEL_BIT9: sel = 9;
                    SEL_BIT3: sel = 3;
                    SEL_BIT5: sel = 5;
                    default:  sel = 7;
                endcase
                was_waiting = overflow_wait;
                div_count = div_count + 16'd1;
                gate = div_count[sel] & ctrl_reg[2];
                if (was_waiting)
                begin
                    if (reload_left != 3'd0)
                        reload_left = reload_left - 3'd1;
                    if (reload_left == 3'd0)
                        r.timer_irq = reload_now();
                end
                else if (prev_gate && !gate)
                begin
                    tick_count = tick_count + 8'd1;
                    if (tick_count == 8'd0)
                    begin
                        overflow_wait = 1'b1;
                        reload_left = RELOAD_TICKS[2:0];
                        if (reload_left == 3'd0)
                            r.timer_irq = reload_now();
                    end
                end
                prev_gate = gate;
            end
            KIND_READ:
            begin
                case (c.address)
                    ADDR_DIV:  r.read_data = div_count[15:8];
                    ADDR_TIMA: r.read_data = tick_count;
                    ADDR_TMA:  r.read_data = reload_value;
                    ADDR_TAC:  r.read_data = ctrl_reg;
                    default:   r.read_data = UNMAPPED_DATA;
                endcase
            end
            KIND_WRITE:
            begin
                case (c.address)
                    ADDR_DIV:  div_count = '0;
                    ADDR_TIMA: tick_count = c.write_data;
                    ADDR_TMA:  reload_value = c.write_data;
                    ADDR_TAC:  ctrl_reg = c.write_data | TAC_FORCE;
                    default:   ;
                endcase
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic plan_row_t step_row(input kind_t k, input logic [15:0] a,
                                           input logic [7:0] d, input int unsigned n,
                                           input bit pre, input logic [7:0] rd);
        plan_row_t p;
        p.cmd.kind = k;
        p.cmd.address = a;
        p.cmd.write_data = d;
        p.reps = n;
        p.preset = pre;
        p.read_data = rd;
        return p;
    endfunction

    function automatic cmd_item_t pick_item();
        cmd_item_t it;
        int unsigned roll;
        it.kind = KIND_TICK;
        it.address = 16'($urandom());
        it.write_data = 8'($urandom_range(0, 255));
        roll = $urandom_range(0, 99);
        if (roll < 74)
            it.kind = KIND_TICK;
        else if (roll < 87)
        begin
            it.kind = KIND_READ;
            if ($urandom_range(0, 5) != 0)
                it.address = 16'($urandom_range(ADDR_DIV, ADDR_TAC));
        end
        else if (roll < 97)
        begin
            it.kind = KIND_WRITE;
            case ($urandom_range(0, 5))
                0: it.address = ADDR_DIV;
                1, 2:
                begin
                    it.address = ADDR_TIMA;
                    if ($urandom_range(0, 3) != 0)
                        it.write_data = 8'($urandom_range(8'hF8, 8'hFF));
                end
                3:
                begin
                    it.address = ADDR_TMA;
                    if ($urandom_range(0, 3) != 0)
                        it.write_data = 8'($urandom_range(8'hF0, 8'hFF));
                end
                4:
                begin
                    it.address = ADDR_TAC;
                    if ($urandom_range(0, 7) != 0)
                        it.write_data[2] = 1'b1;
                    if ($urandom_range(0, 4) != 0)
                        it.write_data[1:0] = 2'($urandom_range(SEL_BIT3, SEL_BIT5));
                end
                default: ;
            endcase
        end
        else
            it.kind = KIND_NONE;
        return it;
    endfunction

    task automatic send_cmd(input cmd_item_t it, input bit pre, input rsp_item_t fixed);
        preset_t note;
        while (idle_roll())
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        note.preset = pre;
        note.value = fixed;
        preset_q.push_back(note);
        cmd_ch.valid <= 1'b1;
        cmd_ch.item <= it;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding", cycles,
                     due_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    always @(posedge clk)
        rsp_ch.ready <= rst_n && !idle_roll();

    always @(posedge clk)
    begin : monitor
        rsp_item_t want;
        rsp_item_t got;
        preset_t   note;
        if (rst_n)
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                case (cmd_ch.item.kind)
                    KIND_TICK:  n_ticks++;
                    KIND_READ:  n_reads++;
                    KIND_WRITE: n_writes++;
                    default:    n_other++;
                endcase
                want = timer_step(cmd_ch.item);
                if (want.timer_irq)
                    irq_total++;
                note = preset_q.pop_front();
                if (note.preset)
                    want = note.value;
                due_results.push_back(want);
            end
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got = rsp_ch.item;
                if (due_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("unexpected result: read_data %h timer_irq %b",
                                 got.read_data, got.timer_irq);
                end
                else
                begin
                    want = due_results.pop_front();
                    if (got.read_data !== want.read_data ||
                        got.timer_irq !== want.timer_irq)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("result %0d: read_data exp %h got %h, timer_irq exp %b got %b",
                                     n_checked, want.read_data, got.read_data,
                                     want.timer_irq, got.timer_irq);
                    end
                end
                n_checked++;
            end
        end
    end

    initial
    begin : stimulus
        cmd_item_t   it;
        rsp_item_t   fixed;
        int unsigned counted;
        cmd_ch.valid = 1'b0;
        cmd_ch.item = '0;

        // after reset, unmapped reads, unknown kind, control write and readback
        plan.push_back(step_row(KIND_READ, ADDR_DIV, 8'h00, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_READ, ADDR_TIMA, 8'h00, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_READ, ADDR_TAC, 8'h00, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_READ, 16'h0000, 8'h00, 1, 1'b1, UNMAPPED_DATA));
        plan.push_back(step_row(KIND_READ, 16'hFFFF, 8'h00, 1, 1'b1, UNMAPPED_DATA));
        plan.push_back(step_row(KIND_NONE, 16'hFFFF, 8'hFF, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_WRITE, ADDR_TAC, 8'h05, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_READ, ADDR_TAC, 8'h00, 1, 1'b1, 8'hFD));
        // gate high, then divider clear gives a falling edge that overflows
        plan.push_back(step_row(KIND_TICK, 16'h0000, 8'h00, 8, 1'b0, 8'h00));
        plan.push_back(step_row(KIND_WRITE, ADDR_TIMA, 8'hFF, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_WRITE, ADDR_DIV, 8'h3C, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_TICK, 16'hFFFF, 8'hFF, 1, 1'b0, 8'h00));
        // writes during the pending reload; reload takes the new modulo
        plan.push_back(step_row(KIND_WRITE, ADDR_TMA, 8'h42, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_WRITE, ADDR_TIMA, 8'h10, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_TICK, 16'h1234, 8'h00, RELOAD_TICKS, 1'b0, 8'h00));
        plan.push_back(step_row(KIND_READ, ADDR_TIMA, 8'h00, 1, 1'b0, 8'h00));
        plan.push_back(step_row(KIND_WRITE, 16'hFF03, 8'hAA, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_WRITE, ADDR_TAC, 8'h02, 1, 1'b1, 8'h00));
        plan.push_back(step_row(KIND_READ, ADDR_TAC, 8'h00, 1, 1'b1, 8'hFA));

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            fixed.read_data = plan[i].read_data;
            fixed.timer_irq = 1'b0;
            repeat (plan[i].reps)
                send_cmd(plan[i].cmd, plan[i].preset, fixed);
        end

        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            calm = (counted >= 700 && counted < 1000);
            it = pick_item();
            send_cmd(it, 1'b0, '0);
            counted++;
        end
        cmd_ch.valid <= 1'b0;
        calm = 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d ticks, %0d reads, %0d writes, %0d unknown-kind transactions",
                 n_ticks, n_reads, n_writes, n_other);
        $display("%0d results checked, %0d reload interrupts, %0d mismatches",
                 n_checked, irq_total, mismatches);
        if (mismatches == 0 && due_results.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+src
src/dtm_pkg.sv
src/dtm_cmd_if.sv
src/dtm_rsp_if.sv
src/dtm_core.sv
src/divider_timer_with_modulo_reload.sv
tb/sv/tb_top.sv
